// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every edge outside reset.
`define LL1GC_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ll1gc assertion failed");

// Trigger at one edge implies result at the next.
`define LL1GC_ASSERT_NEXT(lbl, trig, res) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res)) \
    else $error("ll1gc assertion failed");

`else

`define LL1GC_ASSERT(lbl, cond)
`define LL1GC_ASSERT_NEXT(lbl, trig, res)

`endif

`endif

// ----- hdl/ll1gc_pkg.sv -----
`default_nettype none
package ll1gc_pkg;

  localparam int TOKEN_W  = 6;
  localparam int SYM_W    = 6;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 16;
  localparam int EXP_W    = 4;
  localparam int RHS_MAX  = 4;

  typedef logic [SYM_W-1:0]    sym_t;
  typedef logic [STATUS_W-1:0] status_t;

  // result codes
  localparam status_t ST_MATCH     = 3'd0;
  localparam status_t ST_MISMATCH  = 3'd1;
  localparam status_t ST_END_ERR   = 3'd2;
  localparam status_t ST_NO_RULE   = 3'd3;
  localparam status_t ST_SUCCESS   = 3'd4;
  localparam status_t ST_AFTER     = 3'd5;
  localparam status_t ST_OVERFLOW  = 3'd6;

  // terminals (same code as the lexer class)
  localparam sym_t SYM_END   = 6'd0;
  localparam sym_t T_MAIN    = 6'd1;
  localparam sym_t T_IF      = 6'd6;
  localparam sym_t T_ELSE    = 6'd7;
  localparam sym_t T_DO      = 6'd8;
  localparam sym_t T_WHILE   = 6'd9;
  localparam sym_t T_ID      = 6'd10;
  localparam sym_t T_NUM     = 6'd20;
  localparam sym_t T_ASSIGN  = 6'd21;
  localparam sym_t T_PLUS    = 6'd22;
  localparam sym_t T_MINUS   = 6'd23;
  localparam sym_t T_MUL     = 6'd24;
  localparam sym_t T_DIV     = 6'd25;
  localparam sym_t T_LP      = 6'd26;
  localparam sym_t T_RP      = 6'd27;
  localparam sym_t T_LB      = 6'd28;
  localparam sym_t T_RB      = 6'd29;
  localparam sym_t T_SEMI    = 6'd31;
  localparam sym_t T_GT      = 6'd32;
  localparam sym_t T_NE      = 6'd37;
  localparam sym_t SYM_BAD   = 6'd63;

  // nonterminals
  localparam sym_t NT_S  = 6'd40;
  localparam sym_t NT_A  = 6'd41;
  localparam sym_t NT_B  = 6'd42;
  localparam sym_t NT_C  = 6'd43;
  localparam sym_t NT_CT = 6'd44;
  localparam sym_t NT_D  = 6'd45;
  localparam sym_t NT_E  = 6'd46;
  localparam sym_t NT_X  = 6'd47;
  localparam sym_t NT_F  = 6'd48;
  localparam sym_t NT_H  = 6'd49;
  localparam sym_t NT_G  = 6'd50;
  localparam sym_t NT_I  = 6'd51;
  localparam sym_t NT_J  = 6'd52;
  localparam sym_t NT_JT = 6'd53;
  localparam sym_t NT_K  = 6'd54;
  localparam sym_t NT_KT = 6'd55;

  typedef struct packed {
    logic                    ok;
    logic [2:0]              len;
    sym_t [RHS_MAX-1:0]      rhs;   // rhs[0] is leftmost
  } rule_t;

  // microcode
  typedef logic [2:0] step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FETCH,
    OP_POP,
    OP_DECODE,
    OP_PUSH,
    OP_COUNT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_FINISHED,
    COND_EMPTY,
    COND_RESOLVED,
    COND_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic no_item;
    logic finished;
    logic empty;
    logic resolved;
    logic more;
    logic out_busy;
  } flags_t;

  localparam step_t S_FETCH  = 3'd0;
  localparam step_t S_CHECK  = 3'd1;
  localparam step_t S_POP    = 3'd2;
  localparam step_t S_DECODE = 3'd3;
  localparam step_t S_PUSH   = 3'd4;
  localparam step_t S_COUNT  = 3'd5;
  localparam step_t S_EMIT   = 3'd6;
  localparam step_t S_RETURN = 3'd7;

  // Control store. A taken condition jumps to target, else fall through.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      S_FETCH:  w = '{op: OP_FETCH,  cond: COND_NO_ITEM,  target: S_FETCH};
      S_CHECK:  w = '{op: OP_NONE,   cond: COND_FINISHED, target: S_EMIT};
      S_POP:    w = '{op: OP_POP,    cond: COND_EMPTY,    target: S_EMIT};
      S_DECODE: w = '{op: OP_DECODE, cond: COND_RESOLVED, target: S_EMIT};
      S_PUSH:   w = '{op: OP_PUSH,   cond: COND_MORE,     target: S_PUSH};
      S_COUNT:  w = '{op: OP_COUNT,  cond: COND_ALWAYS,   target: S_POP};
      S_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, target: S_EMIT};
      default:  w = '{op: OP_NONE,   cond: COND_ALWAYS,   target: S_FETCH};
    endcase
    return w;
  endfunction

  function automatic sym_t map_token(input logic [TOKEN_W-1:0] code);
    if (code inside {6'd0, 6'd1, [6'd6:6'd10], [6'd20:6'd29], [6'd31:6'd39]})
      return code;
    return SYM_BAD;
  endfunction

  function automatic rule_t mk_rule(input logic [2:0] len, input sym_t s0,
                                    input sym_t s1, input sym_t s2, input sym_t s3);
    rule_t r;
    r.ok     = 1'b1;
    r.len    = len;
    r.rhs[0] = s0;
    r.rhs[1] = s1;
    r.rhs[2] = s2;
    r.rhs[3] = s3;
    return r;
  endfunction

  // Production table: nonterminal x with lookahead a.
  function automatic rule_t find_rule(input sym_t x, input sym_t a);
    rule_t r;
    logic  expr;
    logic  stmt;
    logic  relop;
    r     = '0;
    expr  = a inside {T_LP, T_ID, T_NUM};
    stmt  = a inside {T_IF, T_DO, T_ID};
    relop = a inside {[T_GT:T_NE]};
    case (x)
      NT_S:  if (a == T_MAIN) r = mk_rule(3'd4, T_MAIN, T_LP, T_RP, NT_A);
      NT_A:  if (a == T_LB) r = mk_rule(3'd3, T_LB, NT_B, T_RB, SYM_END);
      NT_B:  if (stmt) r = mk_rule(3'd3, NT_C, T_SEMI, NT_CT, SYM_END);
      NT_C: begin
        if (a == T_IF)      r = mk_rule(3'd1, NT_E, SYM_END, SYM_END, SYM_END);
        else if (a == T_DO) r = mk_rule(3'd1, NT_F, SYM_END, SYM_END, SYM_END);
        else if (a == T_ID) r = mk_rule(3'd1, NT_D, SYM_END, SYM_END, SYM_END);
        else if (a == T_RB) r = mk_rule(3'd0, SYM_END, SYM_END, SYM_END, SYM_END);
      end
      NT_CT: begin
        if (a == T_RB) r = mk_rule(3'd0, SYM_END, SYM_END, SYM_END, SYM_END);
        else if (stmt) r = mk_rule(3'd3, NT_C, T_SEMI, NT_CT, SYM_END);
      end
      NT_D:  if (a == T_ID) r = mk_rule(3'd3, T_ID, T_ASSIGN, NT_G, SYM_END);
      NT_E:  if (a == T_IF) r = mk_rule(3'd4, T_IF, NT_H, NT_A, NT_X);
      NT_X: begin
        if (a == T_ELSE)      r = mk_rule(3'd2, T_ELSE, NT_A, SYM_END, SYM_END);
        else if (a == T_SEMI) r = mk_rule(3'd0, SYM_END, SYM_END, SYM_END, SYM_END);
      end
      NT_F:  if (a == T_DO) r = mk_rule(3'd4, T_DO, NT_A, T_WHILE, NT_H);
      NT_H:  if (expr) r = mk_rule(3'd3, NT_G, NT_I, NT_G, SYM_END);
      NT_G:  if (expr) r = mk_rule(3'd2, NT_J, NT_JT, SYM_END, SYM_END);
      NT_I:  if (relop) r = mk_rule(3'd1, a, SYM_END, SYM_END, SYM_END);
      NT_J:  if (expr) r = mk_rule(3'd2, NT_K, NT_KT, SYM_END, SYM_END);
      NT_JT, NT_KT: begin
        // expression tails share one rule set
        if (a inside {T_PLUS, T_MINUS})
          r = mk_rule(3'd3, a, NT_J, NT_JT, SYM_END);
        else if (a inside {T_MUL, T_DIV})
          r = mk_rule(3'd3, a, NT_K, NT_KT, SYM_END);
        else if (relop || a inside {T_RP, T_LB, T_SEMI})
          r = mk_rule(3'd0, SYM_END, SYM_END, SYM_END, SYM_END);
      end
      NT_K: begin
        if (a == T_LP)                 r = mk_rule(3'd3, T_LP, NT_G, T_RP, SYM_END);
        else if (a inside {T_ID, T_NUM}) r = mk_rule(3'd1, a, SYM_END, SYM_END, SYM_END);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ll1gc_token_if.sv -----
`default_nettype none
interface ll1gc_token_if;
  import ll1gc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOKEN_W-1:0] token_code;

  modport source (output valid, output token_code, input ready);
  modport sink   (input valid, input token_code, output ready);
endinterface
`default_nettype wire

// ----- hdl/ll1gc_result_if.sv -----
`default_nettype none
interface ll1gc_result_if;
  import ll1gc_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    position;
  logic [EXP_W-1:0]    expansions;

  modport source (output valid, output status, output position, output expansions,
                  input ready);
  modport sink   (input valid, input status, input position, input expansions,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/ll1gc_ram.sv -----
`default_nettype none
module ll1gc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/ll1gc_useq.sv -----
`default_nettype none
module ll1gc_useq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ll1gc_pkg::flags_t flags,
  output ll1gc_pkg::ctrl_t       ctrl
);
  import ll1gc_pkg::*;

  step_t  step;
  step_t  step_next;
  uword_t uw;
  logic   taken;

  assign uw = ucode(step);

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_ITEM:  taken = flags.no_item;
      COND_FINISHED: taken = flags.finished;
      COND_EMPTY:    taken = flags.empty;
      COND_RESOLVED: taken = flags.resolved;
      COND_MORE:     taken = flags.more;
      COND_OUT_BUSY: taken = flags.out_busy;
      default:       taken = 1'b0;
    endcase
  end

  always_comb begin
    step_next = taken ? uw.target : step + step_t'(1);
  end

  always_comb begin
    ctrl.op = uw.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ll1gc_dpath.sv -----
`default_nettype none
`include "assert_macros.svh"
module ll1gc_dpath #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  ll1gc_token_if.sink           token,
  ll1gc_result_if.source        result,
  input  wire ll1gc_pkg::ctrl_t ctrl,
  output ll1gc_pkg::flags_t     flags
);
  import ll1gc_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [SPW-1:0]   sp;
  logic [SPW-1:0]   sp_dec;
  logic [POS_W-1:0] counter;
  logic             finished;
  logic [1:0]       written;     // bottom two entries have reset contents
  sym_t             tok;
  logic [POS_W-1:0] pos;
  logic [EXP_W-1:0] expn;
  status_t          status;
  rule_t            rule_q;
  logic [2:0]       cnt;
  logic [2:0]       cnt_dec;

  logic             out_valid;
  status_t          out_status;
  logic [POS_W-1:0] out_pos;
  logic [EXP_W-1:0] out_expn;
  logic             busy;

  logic             we;
  logic [AW-1:0]    waddr;
  sym_t             wdata;
  sym_t             rdata;

  sym_t             x_sym;
  rule_t            dec_rule;
  logic             overflow;
  logic             resolved;

  assign sp_dec  = sp - SPW'(1);
  assign cnt_dec = cnt - 3'd1;
  assign waddr   = sp[AW-1:0];
  assign we      = (ctrl.op == OP_PUSH) && (cnt != 3'd0);
  assign wdata   = rule_q.rhs[cnt_dec[1:0]];

  ll1gc_ram #(
    .WIDTH (SYM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (sp_dec[AW-1:0]),
    .rdata (rdata)
  );

  // top-of-stack symbol, read issued during the pop step
  always_comb begin
    if ((sp < SPW'(2)) && !written[sp[0]]) begin
      x_sym = (sp == SPW'(0)) ? SYM_END : NT_S;
    end else begin
      x_sym = rdata;
    end
    dec_rule = find_rule(x_sym, tok);
    overflow = ((SPW+1)'(sp) + (SPW+1)'(dec_rule.len)) > (SPW+1)'(STACK_DEPTH);
    resolved = (x_sym < NT_S) || !dec_rule.ok || overflow;
  end

  assign busy = out_valid && !result.ready;

  always_comb begin
    flags.no_item  = !token.valid;
    flags.finished = finished;
    flags.empty    = (sp == SPW'(0));
    flags.resolved = resolved;
    flags.more     = (cnt > 3'd1);
    flags.out_busy = busy;
  end

  // no item is taken while reset is held
  assign token.ready       = (ctrl.op == OP_FETCH) && !rst;
  assign result.valid      = out_valid;
  assign result.status     = out_status;
  assign result.position   = out_pos;
  assign result.expansions = out_expn;

  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= SPW'(2);
      counter   <= '0;
      finished  <= 1'b0;
      written   <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // a new result may load in the same cycle the old one is taken
      if ((ctrl.op == OP_EMIT) && !busy) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_FETCH: if (token.valid) begin
          tok    <= map_token(token.token_code);
          pos    <= counter;
          expn   <= '0;
          status <= finished ? ST_AFTER : ST_MATCH;
          if (counter != '1) begin
            counter <= counter + POS_W'(1);
          end
        end
        OP_POP: begin
          if (sp == SPW'(0)) begin
            status   <= ST_END_ERR;
            finished <= 1'b1;
          end else begin
            sp <= sp_dec;
          end
        end
        OP_DECODE: begin
          if (x_sym == SYM_END) begin
            status   <= (tok == SYM_END) ? ST_SUCCESS : ST_END_ERR;
            finished <= 1'b1;
          end else if (x_sym < NT_S) begin
            if (x_sym != tok) begin
              status   <= ST_MISMATCH;
              finished <= 1'b1;
            end
          end else if (!dec_rule.ok) begin
            status   <= ST_NO_RULE;
            finished <= 1'b1;
          end else if (overflow) begin
            status   <= ST_OVERFLOW;
            finished <= 1'b1;
          end else begin
            rule_q <= dec_rule;
            cnt    <= dec_rule.len;
          end
        end
        OP_PUSH: if (cnt != 3'd0) begin
          sp  <= sp + SPW'(1);
          cnt <= cnt_dec;
          if (waddr < AW'(2)) begin
            written[waddr[0]] <= 1'b1;
          end
        end
        OP_COUNT: if (expn != '1) begin
          expn <= expn + EXP_W'(1);
        end
        OP_EMIT: if (!busy) begin
          out_status <= status;
          out_pos    <= pos;
          out_expn   <= expn;
        end
        default: ;
      endcase
    end
  end

  `LL1GC_ASSERT(a_sp_bound, sp <= SPW'(STACK_DEPTH))
  `LL1GC_ASSERT(a_cnt_bound, cnt <= 3'd4)
  `LL1GC_ASSERT_NEXT(a_finish_sticky, finished, finished)
  `LL1GC_ASSERT_NEXT(a_push_in_range, we, sp <= SPW'(STACK_DEPTH))

endmodule
`default_nettype wire

// ----- hdl/ll1_token_grammar_checker_top.sv -----
`default_nettype none
// LL(1) token grammar checker.
// token channel: one lexer class code per item (token_code, 6 bits).
// result channel: one item per token: status, position in the stream
//   (saturating at 65535) and the number of productions applied (max 15).
// A small microcode sequencer steps a stack datapath. Each production
// applied pushes its len symbols one per push step through the single
// stack write port. Once the parse has finished (success or error), a
// token goes straight to its emit step.
// The result item is presented the cycle after its emit step and sits in
// an output register; the next token is taken while it waits. If the
// receiver stalls and a second result is ready, the sequencer holds in its
// emit step until the register frees up, and takes no token meanwhile.
// Reset (synchronous, rst high): stack holds end marker below start
// symbol, token counter zero, parse not finished, result channel empty.
// Any outcome other than a plain match ends the parse; later tokens report
// "after finish" until the next reset.
module ll1_token_grammar_checker_top #(
  parameter int STACK_DEPTH = 64   // symbol stack entries, 16..1024
) (
  input  wire logic      clk,
  input  wire logic      rst,
  ll1gc_token_if.sink    token,
  ll1gc_result_if.source result
);
  import ll1gc_pkg::*;

  ctrl_t  ctrl;    // control word from the sequencer
  flags_t flags;   // branch conditions back to it

  ll1gc_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // stack, token register, counters and result register
  ll1gc_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .token  (token),
    .result (result),
    .ctrl   (ctrl),
    .flags  (flags)
  );

endmodule
`default_nettype wire
